[sv/mkseg_pkg.sv]
// Shared types, constants and the character code table for the Morse segment encoder.
// No dependencies; every other file of the block refers to this package by scope.
`default_nettype none

package mkseg_pkg;

   localparam int CHAR_W      = 8;
   localparam int UNIT_W      = 8;
   localparam int DUR_W       = 11;
   localparam int UCOUNT_W    = 3;
   localparam int SYM_MAX     = 5;
   localparam int SCOUNT_W    = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [UNIT_W-1:0]   UNIT_RESET     = 8'd100;
   localparam logic [UCOUNT_W-1:0] SPACE_UNITS    = 3'd7;
   localparam logic [UCOUNT_W-1:0] DOT_UNITS      = 3'd1;
   localparam logic [UCOUNT_W-1:0] DASH_UNITS     = 3'd3;
   localparam logic [UCOUNT_W-1:0] GAP_UNITS      = 3'd1;
   localparam logic [UCOUNT_W-1:0] CHAR_END_UNITS = 3'd2;

   localparam logic [CHAR_W-1:0] CASE_MASK = 8'hDF;

   // symbols are left aligned: first symbol in the top bit, 1 = dash
   typedef struct packed {
      logic                is_space;
      logic [SCOUNT_W-1:0] count;
      logic [SYM_MAX-1:0]  symbols;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_wr_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_rd_type;

   typedef struct packed {
      logic      keep;
      entry_type entry;
   } char_class_type;

   function automatic char_class_type classify(input logic [CHAR_W-1:0] c);
      char_class_type r;
      logic [CHAR_W-1:0] up;
      r  = '0;
      up = c & CASE_MASK;
      r.keep = 1'b1;
      if (c == " ") begin
         r.entry.is_space = 1'b1;
      end else if (c >= "0" && c <= "9") begin
         r.entry.count = 3'd5;
         unique case (c)
            "0": r.entry.symbols = 5'b11111;
            "1": r.entry.symbols = 5'b01111;
            "2": r.entry.symbols = 5'b00111;
            "3": r.entry.symbols = 5'b00011;
            "4": r.entry.symbols = 5'b00001;
            "5": r.entry.symbols = 5'b00000;
            "6": r.entry.symbols = 5'b10000;
            "7": r.entry.symbols = 5'b11000;
            "8": r.entry.symbols = 5'b11100;
            "9": r.entry.symbols = 5'b11110;
            default: r.entry.symbols = 5'b00000;
         endcase
      end else begin
         unique case (up)
            "A": begin r.entry.count = 3'd2; r.entry.symbols = 5'b01000; end
            "B": begin r.entry.count = 3'd4; r.entry.symbols = 5'b10000; end
            "C": begin r.entry.count = 3'd4; r.entry.symbols = 5'b10100; end
            "D": begin r.entry.count = 3'd3; r.entry.symbols = 5'b10000; end
            "E": begin r.entry.count = 3'd1; r.entry.symbols = 5'b00000; end
            "F": begin r.entry.count = 3'd4; r.entry.symbols = 5'b00100; end
            "G": begin r.entry.count = 3'd3; r.entry.symbols = 5'b11000; end
            "H": begin r.entry.count = 3'd4; r.entry.symbols = 5'b00000; end
            "I": begin r.entry.count = 3'd2; r.entry.symbols = 5'b00000; end
            "J": begin r.entry.count = 3'd4; r.entry.symbols = 5'b01110; end
            "K": begin r.entry.count = 3'd3; r.entry.symbols = 5'b10100; end
            "L": begin r.entry.count = 3'd4; r.entry.symbols = 5'b01000; end
            "M": begin r.entry.count = 3'd2; r.entry.symbols = 5'b11000; end
            "N": begin r.entry.count = 3'd2; r.entry.symbols = 5'b10000; end
            "O": begin r.entry.count = 3'd3; r.entry.symbols = 5'b11100; end
            "P": begin r.entry.count = 3'd4; r.entry.symbols = 5'b01100; end
            "Q": begin r.entry.count = 3'd4; r.entry.symbols = 5'b11010; end
            "R": begin r.entry.count = 3'd3; r.entry.symbols = 5'b01000; end
            "S": begin r.entry.count = 3'd3; r.entry.symbols = 5'b00000; end
            "T": begin r.entry.count = 3'd1; r.entry.symbols = 5'b10000; end
            "U": begin r.entry.count = 3'd3; r.entry.symbols = 5'b00100; end
            "V": begin r.entry.count = 3'd4; r.entry.symbols = 5'b00010; end
            "W": begin r.entry.count = 3'd3; r.entry.symbols = 5'b01100; end
            "X": begin r.entry.count = 3'd4; r.entry.symbols = 5'b10010; end
            "Y": begin r.entry.count = 3'd4; r.entry.symbols = 5'b10110; end
            "Z": begin r.entry.count = 3'd4; r.entry.symbols = 5'b11000; end
            default: r.keep = 1'b0;
         endcase
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[sv/mkseg_if.sv]
// Valid/ready channel interfaces for character requests and segment responses.
// Depends on mkseg_pkg for field widths.
`default_nettype none

interface mkseg_req_if;
   logic                       valid;
   logic                       ready;
   logic [mkseg_pkg::CHAR_W-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

interface mkseg_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        lamp_on;
   logic [mkseg_pkg::DUR_W-1:0] duration_ms;
   logic                        last;

   modport source (output valid, output lamp_on, output duration_ms, output last, input ready);
   modport sink (input valid, input lamp_on, input duration_ms, input last, output ready);
endinterface

`default_nettype wire

[sv/mkseg_front.sv]
// Front end: accepts characters, classifies them and pushes coded entries to the queue.
// Depends on mkseg_pkg and mkseg_req_if; characters with no code are dropped here.
`default_nettype none

module mkseg_front (
   input  wire logic                    reset,
   mkseg_req_if.sink                    req_chan,
   input  wire logic                    queue_full,
   output mkseg_pkg::queue_wr_type      queue_wr
);

   mkseg_pkg::char_class_type cls;

   always_comb begin
      cls               = mkseg_pkg::classify(req_chan.char_code);
      req_chan.ready    = !queue_full && !reset;
      queue_wr.valid    = req_chan.valid && req_chan.ready && cls.keep;
      queue_wr.entry    = cls.entry;
   end

endmodule

`default_nettype wire

[sv/mkseg_queue.sv]
// Short register queue between the front and back ends.
// Depends on mkseg_pkg for the entry type and depth.
`default_nettype none

module mkseg_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire mkseg_pkg::queue_wr_type queue_wr,
   output logic                         queue_full,
   output mkseg_pkg::queue_rd_type      queue_rd,
   input  wire logic                    queue_pop
);

   mkseg_pkg::entry_type              slot_ff [mkseg_pkg::QUEUE_DEPTH];
   logic [mkseg_pkg::QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [mkseg_pkg::QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [mkseg_pkg::QUEUE_AW:0]      count_ff, count_in;
   logic                              do_push, do_pop;

   always_comb begin
      queue_full     = (count_ff == (mkseg_pkg::QUEUE_AW+1)'(mkseg_pkg::QUEUE_DEPTH));
      queue_rd.valid = (count_ff != '0);
      queue_rd.entry = slot_ff[rd_ptr_ff];
      do_push        = queue_wr.valid && !queue_full;
      do_pop         = queue_pop && queue_rd.valid;
      wr_ptr_in      = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in      = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in       = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= queue_wr.entry;
      end
   end

endmodule

`default_nettype wire

[sv/mkseg_back.sv]
// Back end: steps through one coded character and emits its lamp segments.
// Depends on mkseg_pkg and mkseg_rsp_if; the response is held in an output register.
`default_nettype none

module mkseg_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [mkseg_pkg::UNIT_W-1:0]  unit_ms,
   input  wire mkseg_pkg::queue_rd_type       queue_rd,
   output logic                               queue_pop,
   mkseg_rsp_if.source                        rsp_chan
);

   logic                              busy_ff, busy_in;
   logic                              space_ff, space_in;
   logic                              gap_ff, gap_in;
   logic [mkseg_pkg::SCOUNT_W-1:0]    rem_ff, rem_in;
   logic [mkseg_pkg::SYM_MAX-1:0]     sym_ff, sym_in;
   logic                              out_valid_ff, out_valid_in;
   logic                              out_lamp_ff, out_lamp_in;
   logic [mkseg_pkg::DUR_W-1:0]       out_dur_ff, out_dur_in;
   logic                              out_last_ff, out_last_in;
   logic                              out_load, advance;
   logic                              seg_lamp, seg_last;
   logic [mkseg_pkg::UCOUNT_W-1:0]    seg_units;

   always_comb begin
      out_load  = !out_valid_ff || rsp_chan.ready;
      advance   = busy_ff && out_load;
      queue_pop = !busy_ff && queue_rd.valid;

      busy_in  = busy_ff;
      space_in = space_ff;
      gap_in   = gap_ff;
      rem_in   = rem_ff;
      sym_in   = sym_ff;

      seg_lamp  = 1'b0;
      seg_last  = 1'b0;
      seg_units = mkseg_pkg::GAP_UNITS;

      if (space_ff) begin
         seg_units = mkseg_pkg::SPACE_UNITS;
         seg_last  = 1'b1;
      end else if (rem_ff == '0) begin
         seg_units = mkseg_pkg::CHAR_END_UNITS;
         seg_last  = 1'b1;
      end else if (!gap_ff) begin
         seg_lamp  = 1'b1;
         seg_units = sym_ff[mkseg_pkg::SYM_MAX-1] ? mkseg_pkg::DASH_UNITS
                                                  : mkseg_pkg::DOT_UNITS;
      end

      if (queue_pop) begin
         busy_in  = 1'b1;
         space_in = queue_rd.entry.is_space;
         gap_in   = 1'b0;
         rem_in   = queue_rd.entry.count;
         sym_in   = queue_rd.entry.symbols;
      end else if (advance) begin
         if (seg_last) begin
            busy_in = 1'b0;
         end else if (!gap_ff) begin
            gap_in = 1'b1;
         end else begin
            gap_in = 1'b0;
            rem_in = rem_ff - 1'b1;
            sym_in = {sym_ff[mkseg_pkg::SYM_MAX-2:0], 1'b0};
         end
      end

      out_valid_in = out_load ? advance : out_valid_ff;
      out_lamp_in  = advance ? seg_lamp : out_lamp_ff;
      out_last_in  = advance ? seg_last : out_last_ff;
      out_dur_in   = advance ? mkseg_pkg::DUR_W'(unit_ms) * mkseg_pkg::DUR_W'(seg_units)
                             : out_dur_ff;

      rsp_chan.valid       = out_valid_ff;
      rsp_chan.lamp_on     = out_lamp_ff;
      rsp_chan.duration_ms = out_dur_ff;
      rsp_chan.last        = out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      space_ff    <= space_in;
      gap_ff      <= gap_in;
      rem_ff      <= rem_in;
      sym_ff      <= sym_in;
      out_lamp_ff <= out_lamp_in;
      out_dur_ff  <= out_dur_in;
      out_last_ff <= out_last_in;
   end

endmodule

`default_nettype wire

[sv/morse_keyer_segment_encoder_unit.sv]
// Morse segment encoder top level: unit length register, front end, queue, back end.
// An accepted character goes into the queue, then the back end state, then the output register.
// Throughput: one segment per cycle within a character while the response sink is ready;
// a character is popped only when the back end is idle; the back end sequencer sets the rate.
// Reset: unit length returns to 100 ms, queue and output register empty.
`default_nettype none

module morse_keyer_segment_encoder_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   mkseg_req_if.sink                         req_chan,
   mkseg_rsp_if.source                       rsp_chan,
   input  wire logic                         csr_wr_en,
   input  wire logic [mkseg_pkg::UNIT_W-1:0] csr_wr_data
);

   logic [mkseg_pkg::UNIT_W-1:0] unit_ms_ff, unit_ms_in;
   mkseg_pkg::queue_wr_type      queue_wr;
   mkseg_pkg::queue_rd_type      queue_rd;
   logic                         queue_full;
   logic                         queue_pop;

   always_comb begin
      unit_ms_in = csr_wr_en ? csr_wr_data : unit_ms_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ms_ff <= mkseg_pkg::UNIT_RESET;
      end else begin
         unit_ms_ff <= unit_ms_in;
      end
   end

   mkseg_front u_front (
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .queue_wr   (queue_wr)
   );

   mkseg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .queue_wr   (queue_wr),
      .queue_full (queue_full),
      .queue_rd   (queue_rd),
      .queue_pop  (queue_pop)
   );

   mkseg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .unit_ms   (unit_ms_ff),
      .queue_rd  (queue_rd),
      .queue_pop (queue_pop),
      .rsp_chan  (rsp_chan)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(queue_wr.valid && queue_full))
      else $error("push into full queue");

   a_lit_never_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.lamp_on |-> !rsp_chan.last)
      else $error("lit segment flagged last");

   a_lit_duration: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.lamp_on |->
      (rsp_chan.duration_ms == mkseg_pkg::DUR_W'(unit_ms_ff)) ||
      (rsp_chan.duration_ms == mkseg_pkg::DUR_W'(unit_ms_ff) * mkseg_pkg::DUR_W'(3)))
      else $error("lit segment is neither dot nor dash");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid after reset");

endmodule

`default_nettype wire
